@@ hdl/assert_macros.svh @@
// Assertion macros shared by the memory map decoder RTL.
// Depends on clk_i and rst_ni being declared in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define MMD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/mmd_pkg.sv @@
// Types, codes and constants of the memory map decoder.
// No dependencies; imported by every module of the block but mmd_ram.
package mmd_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_UNMAP = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    TGT_IO     = 3'd0,
    TGT_ROM    = 3'd1,
    TGT_SCREEN = 3'd2,
    TGT_RAM    = 3'd3,
    TGT_NONE   = 3'd4
  } target_e;

  localparam logic [3:0]  CFG_RAM_SIZE    = 4'd0;
  localparam logic [3:0]  CFG_SCREEN_MASK = 4'd1;

  localparam logic [15:0] SCREEN_BASE = 16'h8000;
  localparam logic [15:0] SCREEN_LAST = 16'h8FFF;
  localparam logic [15:0] WINDOW_MASK = 16'hF000;
  localparam logic [15:0] CRTC_LO     = 16'hE880;
  localparam logic [15:0] CRTC_HI     = 16'hE881;
  localparam logic [7:0]  OPEN_BUS    = 8'hFF;
  localparam logic [7:0]  BLANK_CHAR  = 8'h20;

  localparam logic [16:0] RAM_SIZE_RESET    = 17'd32768;
  localparam logic [16:0] RAM_SIZE_MAX      = 17'h10000;
  localparam logic [11:0] SCREEN_MASK_RESET = 12'h3FF;

  // ROM word: present flag above the image byte.
  localparam logic [8:0]  ROM_WORD_RESET = 9'h0FF;

  typedef struct packed {
    func_e       func;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [15:0] eff;
  } stage_t;

  typedef struct packed {
    logic [7:0]  read_data;
    target_e     target;
    logic [7:0]  io_register;
    logic        video_write;
    logic [11:0] video_offset;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  data;
  } ram_wr_t;

  function automatic logic in_io(input logic [15:0] addr);
    return (addr inside {[16'hE810:16'hE81F], [16'hE820:16'hE82F], [16'hE840:16'hE84F]})
        || addr == CRTC_LO || addr == CRTC_HI;
  endfunction

endpackage

@@ hdl/mmd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; a read at the address being written returns the old data.
module mmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mmd_clear.sv @@
// Post-reset clearing sequencer sweeping every memory entry once.
// Depends on mmd_pkg for the screen window bounds and fill byte.
module mmd_clear #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     active_o,
  output logic [$clog2(DEPTH)-1:0] addr_o,
  output logic [7:0]               fill_o
);
  import mmd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          active_q, active_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [15:0]   cnt_wide;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == AW'(DEPTH - 1)) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign cnt_wide = 16'(cnt_q);
  assign active_o = active_q;
  assign addr_o   = cnt_q;
  assign fill_o   = (cnt_wide >= SCREEN_BASE && cnt_wide <= SCREEN_LAST) ? BLANK_CHAR : 8'h00;

endmodule

@@ hdl/mmd_decode.sv @@
// Decode of one registered bus access against the memory read data.
// Depends on mmd_pkg; produces the result and the deferred RAM write.
module mmd_decode #(
  parameter int ADDRESS_SPACE = 65536
) (
  input  mmd_pkg::stage_t  stage_i,
  input  logic [16:0]      ram_size_i,
  input  logic [11:0]      screen_mask_i,
  input  logic [8:0]       rom_word_i,
  input  logic [7:0]       ram_byte_i,
  output mmd_pkg::result_t result_o,
  output mmd_pkg::ram_wr_t ram_wr_o
);
  import mmd_pkg::*;

  localparam logic [16:0] SPACE_END = 17'(ADDRESS_SPACE);

  logic addr_in_space, eff_in_space, screen, io, rom, ram;

  assign addr_in_space = {1'b0, stage_i.addr} < SPACE_END;
  assign eff_in_space  = {1'b0, stage_i.eff} < SPACE_END;
  assign screen        = (stage_i.addr & WINDOW_MASK) == SCREEN_BASE;
  assign io            = in_io(stage_i.addr);
  assign rom           = addr_in_space && rom_word_i[8];
  assign ram           = addr_in_space && ({1'b0, stage_i.addr} < ram_size_i);

  always_comb begin
    result_o = '{read_data: 8'h00, target: TGT_NONE, io_register: 8'h00,
                 video_write: 1'b0, video_offset: 12'h000};
    ram_wr_o = '{we: 1'b0, addr: stage_i.addr, data: stage_i.wdata};
    case (stage_i.func)
      FUNC_READ: begin
        if (io) begin
          result_o.target      = TGT_IO;
          result_o.io_register = stage_i.addr[7:0];
        end else if (rom) begin
          result_o.target    = TGT_ROM;
          result_o.read_data = rom_word_i[7:0];
        end else if (screen) begin
          result_o.target    = TGT_SCREEN;
          result_o.read_data = eff_in_space ? ram_byte_i : OPEN_BUS;
        end else if (ram) begin
          result_o.target    = TGT_RAM;
          result_o.read_data = ram_byte_i;
        end else begin
          result_o.read_data = OPEN_BUS;
        end
      end
      FUNC_WRITE: begin
        if (screen) begin
          result_o.target       = TGT_SCREEN;
          result_o.video_write  = 1'b1;
          result_o.video_offset = stage_i.addr[11:0] & screen_mask_i;
          ram_wr_o.we           = eff_in_space;
          ram_wr_o.addr         = stage_i.eff;
        end else if (io) begin
          result_o.target      = TGT_IO;
          result_o.io_register = stage_i.addr[7:0];
        end else if (rom) begin
          result_o.target = TGT_ROM;
        end else if (ram) begin
          result_o.target = TGT_RAM;
          ram_wr_o.we     = 1'b1;
        end
      end
      default: begin
        result_o.target = TGT_ROM;
      end
    endcase
  end

endmodule

@@ hdl/home_computer_memory_map_decoder.sv @@
// Top level of the memory map decoder: input stage, memories and result register.
// Depends on mmd_pkg, mmd_ram, mmd_clear, mmd_decode and assert_macros.svh.
//
//   channel   handshake            payload
//   command   start_i / busy_o     func_i, address_i, write_data_i
//   result    done_o (one cycle)   read_data_o, target_o, io_register_o,
//                                  video_write_o, video_offset_o
//   config    cfg_we_i             cfg_index_i, cfg_data_i
//
// One access is taken in every cycle while busy_o is low; its result is set by the
// input stage register, the registered RAM and ROM read, and the result register.
// After reset a clearing pass over all ADDRESS_SPACE entries fills RAM and ROM, with
// busy_o high; configuration writes are taken throughout.
// Base RAM is written in the cycle after the transfer, once the ROM flag is known;
// a read of that location in the same cycle takes the byte by forwarding.
// The receiver cannot stall, so nothing holds the result back.
module home_computer_memory_map_decoder #(
  parameter int ADDRESS_SPACE = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic [2:0]  target_o,
  output logic [7:0]  io_register_o,
  output logic        video_write_o,
  output logic [11:0] video_offset_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import mmd_pkg::*;

  `include "assert_macros.svh"

  localparam int          AW        = $clog2(ADDRESS_SPACE);
  localparam logic [16:0] SPACE_END = 17'(ADDRESS_SPACE);

  logic [16:0] ram_size_q, ram_size_d;
  logic [11:0] screen_mask_q, screen_mask_d;

  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic [7:0]    clr_fill;

  logic        accept;
  logic        screen_in;
  logic [15:0] eff_in;
  logic [15:0] raddr_in;

  logic   s1_valid_q;
  stage_t s1_q, s1_d;

  logic        fwd_q, fwd_d;
  logic [7:0]  fwd_data_q;

  logic [8:0]  rom_word;
  logic [7:0]  ram_rdata;
  logic [7:0]  ram_byte;

  logic          rom_we;
  logic [AW-1:0] rom_waddr;
  logic [8:0]    rom_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  result_t dec_result;
  ram_wr_t dec_wr;

  logic    done_q;
  result_t result_q;

  // Configuration registers.
  always_comb begin
    ram_size_d    = ram_size_q;
    screen_mask_d = screen_mask_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RAM_SIZE:    ram_size_d    = (cfg_data_i > RAM_SIZE_MAX) ? RAM_SIZE_MAX : cfg_data_i;
        CFG_SCREEN_MASK: screen_mask_d = cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_size_q    <= RAM_SIZE_RESET;
      screen_mask_q <= SCREEN_MASK_RESET;
    end else begin
      ram_size_q    <= ram_size_d;
      screen_mask_q <= screen_mask_d;
    end
  end

  mmd_clear #(
    .DEPTH (ADDRESS_SPACE)
  ) u_clear (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_o (clr_active),
    .addr_o   (clr_addr),
    .fill_o   (clr_fill)
  );

  assign busy_o = clr_active;
  assign accept = start_i && !clr_active;

  // Input stage: address of the memory reads and the ROM load or unmap.
  assign screen_in = (address_i & WINDOW_MASK) == SCREEN_BASE;
  assign eff_in    = SCREEN_BASE | {4'h0, address_i[11:0] & screen_mask_q};
  assign raddr_in  = screen_in ? eff_in : address_i;

  always_comb begin
    s1_d = '{func: func_e'(func_i), addr: address_i, wdata: write_data_i, eff: eff_in};
  end

  always_comb begin
    rom_we    = 1'b0;
    rom_waddr = address_i[AW-1:0];
    rom_wdata = {func_i == FUNC_LOAD, write_data_i};
    if (clr_active) begin
      rom_we    = 1'b1;
      rom_waddr = clr_addr;
      rom_wdata = ROM_WORD_RESET;
    end else if (accept && (func_i == FUNC_LOAD || func_i == FUNC_UNMAP)) begin
      rom_we = {1'b0, address_i} < SPACE_END;
    end
  end

  always_comb begin
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = clr_fill;
    end else begin
      ram_we    = s1_valid_q && dec_wr.we;
      ram_waddr = dec_wr.addr[AW-1:0];
      ram_wdata = dec_wr.data;
    end
  end

  assign fwd_d = s1_valid_q && dec_wr.we && (dec_wr.addr[AW-1:0] == raddr_in[AW-1:0]);

  mmd_ram #(
    .WIDTH (9),
    .DEPTH (ADDRESS_SPACE)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .waddr_i (rom_waddr),
    .wdata_i (rom_wdata),
    .raddr_i (address_i[AW-1:0]),
    .rdata_o (rom_word)
  );

  mmd_ram #(
    .WIDTH (8),
    .DEPTH (ADDRESS_SPACE)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_in[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_byte = fwd_q ? fwd_data_q : ram_rdata;

  mmd_decode #(
    .ADDRESS_SPACE (ADDRESS_SPACE)
  ) u_decode (
    .stage_i       (s1_q),
    .ram_size_i    (ram_size_q),
    .screen_mask_i (screen_mask_q),
    .rom_word_i    (rom_word),
    .ram_byte_i    (ram_byte),
    .result_o      (dec_result),
    .ram_wr_o      (dec_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    fwd_q      <= fwd_d;
    fwd_data_q <= dec_wr.data;
    if (s1_valid_q) begin
      result_q <= dec_result;
    end
  end

  assign done_o         = done_q;
  assign read_data_o    = result_q.read_data;
  assign target_o       = result_q.target;
  assign io_register_o  = result_q.io_register;
  assign video_write_o  = result_q.video_write;
  assign video_offset_o = result_q.video_offset;

  `MMD_ASSERT(a_result_follows, accept |-> ##2 done_o, "transfer without a result")
  `MMD_ASSERT(a_clear_once, !busy_o |=> !busy_o, "clearing pass restarted")
  `MMD_NEVER(a_video_screen, done_o && video_write_o && target_o != TGT_SCREEN,
             "video write outside the screen window")
  `MMD_NEVER(a_io_reg_only_io, done_o && target_o != TGT_IO && io_register_o != 8'h00,
             "I/O register reported for a non-I/O access")

endmodule

@@ test/home_computer_memory_map_decoder_tb.sv @@
// Self-checking testbench of the memory map decoder: directed and random bus accesses,
// with a scoreboard class that keeps its own RAM, ROM and ROM-present state.
// Depends on mmd_pkg and home_computer_memory_map_decoder.
module home_computer_memory_map_decoder_tb;
  import mmd_pkg::*;

  localparam int unsigned SPACE = 65536;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned REPORT_LIMIT = 50;
  localparam logic [3:0] CFG_UNUSED = 4'hF;

  class bus_access_scoreboard;
    logic [7:0] ram_bytes [SPACE];
    logic [7:0] rom_bytes [SPACE];
    bit rom_flag [SPACE];
    logic [16:0] ram_limit;
    logic [11:0] screen_mask;
    result_t pending_results[$];
    int unsigned by_func [4];
    int unsigned checked;
    int unsigned errors;

    function new();
      int unsigned i;
      for (i = 0; i < SPACE; i++) begin
        ram_bytes[i] = ((i & 32'hF000) == SCREEN_BASE) ? BLANK_CHAR : 8'h00;
        rom_bytes[i] = 8'hFF;
        rom_flag[i] = 1'b0;
      end
      ram_limit = RAM_SIZE_RESET;
      screen_mask = SCREEN_MASK_RESET;
      checked = 0;
      errors = 0;
    endfunction

    function void set_register(logic [3:0] idx, logic [16:0] val);
      if (idx == CFG_RAM_SIZE) begin
        ram_limit = (val > RAM_SIZE_MAX) ? RAM_SIZE_MAX : val;
      end else if (idx == CFG_SCREEN_MASK) begin
        screen_mask = val[11:0];
      end
    endfunction

    function bit io_window(logic [15:0] a);
      return (a >= 16'hE810 && a <= 16'hE82F) || (a >= 16'hE840 && a <= 16'hE84F)
          || a == CRTC_LO || a == CRTC_HI;
    endfunction

    function void note_access(func_e f, logic [15:0] a, logic [7:0] d);
      result_t r;
      logic [15:0] eff;
      bit screen;
      bit mapped;
      r = '0;
      r.target = TGT_NONE;
      screen = (a & WINDOW_MASK) == SCREEN_BASE;
      eff = SCREEN_BASE | {4'h0, a[11:0] & screen_mask};
      mapped = a < SPACE;
      by_func[f]++;
      case (f)
        FUNC_READ: begin
          if (io_window(a)) begin
            r.target = TGT_IO;
            r.io_register = a[7:0];
          end else if (mapped && rom_flag[a]) begin
            r.target = TGT_ROM;
            r.read_data = rom_bytes[a];
          end else if (screen) begin
            r.target = TGT_SCREEN;
            r.read_data = (eff < SPACE) ? ram_bytes[eff] : OPEN_BUS;
          end else if (mapped && {1'b0, a} < ram_limit) begin
            r.target = TGT_RAM;
            r.read_data = ram_bytes[a];
          end else begin
            r.read_data = OPEN_BUS;
          end
        end
        FUNC_WRITE: begin
          if (screen) begin
            r.target = TGT_SCREEN;
            if (eff < SPACE) ram_bytes[eff] = d;
            r.video_write = 1'b1;
            r.video_offset = a[11:0] & screen_mask;
          end else if (io_window(a)) begin
            r.target = TGT_IO;
            r.io_register = a[7:0];
          end else if (mapped && rom_flag[a]) begin
            r.target = TGT_ROM;
          end else if (mapped && {1'b0, a} < ram_limit) begin
            r.target = TGT_RAM;
            ram_bytes[a] = d;
          end
        end
        FUNC_LOAD: begin
          r.target = TGT_ROM;
          if (mapped) begin
            rom_bytes[a] = d;
            rom_flag[a] = 1'b1;
          end
        end
        default: begin
          r.target = TGT_ROM;
          if (mapped) rom_flag[a] = 1'b0;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void mismatch(string field, logic [11:0] want, logic [11:0] got);
      if (errors < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
      errors++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no access pending, target %h", $time, got.target);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.read_data !== want.read_data) mismatch("read_data", want.read_data, got.read_data);
      if (got.target !== want.target) mismatch("target", want.target, got.target);
      if (got.io_register !== want.io_register) begin
        mismatch("io_register", want.io_register, got.io_register);
      end
      if (got.video_write !== want.video_write) begin
        mismatch("video_write", want.video_write, got.video_write);
      end
      if (got.video_offset !== want.video_offset) begin
        mismatch("video_offset", want.video_offset, got.video_offset);
      end
    endfunction

    function void flush_leftover();
      while (pending_results.size() != 0) begin
        $display("%0t: expected result never arrived, target %h", $time,
                 pending_results[0].target);
        void'(pending_results.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = FUNC_READ;
  logic [15:0] address_i = 16'h0000;
  logic [7:0] write_data_i = 8'h00;
  logic done_o;
  logic [7:0] read_data_o;
  logic [2:0] target_o;
  logic [7:0] io_register_o;
  logic video_write_o;
  logic [11:0] video_offset_o;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_index_i = CFG_RAM_SIZE;
  logic [16:0] cfg_data_i = 17'd0;
  int unsigned cycles = 0;
  bus_access_scoreboard sb;

  home_computer_memory_map_decoder uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .func_i(func_i),
    .address_i(address_i),
    .write_data_i(write_data_i),
    .done_o(done_o),
    .read_data_o(read_data_o),
    .target_o(target_o),
    .io_register_o(io_register_o),
    .video_write_o(video_write_o),
    .video_offset_o(video_offset_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // A result is checked before a transfer in the same cycle is noted.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        got.read_data = read_data_o;
        got.target = target_e'(target_o);
        got.io_register = io_register_o;
        got.video_write = video_write_o;
        got.video_offset = video_offset_o;
        sb.check_result(got);
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        sb.note_access(func_e'(func_i), address_i, write_data_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_access(func_e f, logic [15:0] a, logic [7:0] d);
    @(negedge clk_i);
    start_i = 1'b1;
    func_i = f;
    address_i = a;
    write_data_i = d;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic pause_sender(int unsigned n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_results.size() != 0 && waited < 100) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
    sb.flush_leftover();
  endtask

  task automatic write_register(logic [3:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    sb.set_register(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic func_e pick_func();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return FUNC_READ;
    if (roll < 7) return FUNC_WRITE;
    if (roll < 9) return FUNC_LOAD;
    return FUNC_UNMAP;
  endfunction

  // Most addresses fall in small pools so that loads, writes and reads meet each other.
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      3: return SCREEN_BASE | 16'($urandom_range(0, 16'hFFF));
      4: return 16'hE800 + 16'($urandom_range(0, 16'h8F));
      5: return 16'hF000 | 16'($urandom_range(0, 31));
      6: return 16'($urandom_range(0, 31));
      7: return 16'(sb.ram_limit - 16 + $urandom_range(0, 31));
      8: return SCREEN_BASE | 16'($urandom_range(0, 15) << 10) | 16'($urandom_range(0, 15));
      9: return 16'h4000 | 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(int unsigned count, bit gaps);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      send_access(pick_func(), pick_address(), 8'($urandom));
      if (gaps && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 17));
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_access(FUNC_READ, 16'h0000, 8'h00);
    send_access(FUNC_WRITE, 16'h0000, 8'hFF);
    send_access(FUNC_READ, 16'h0000, 8'h00);
    send_access(FUNC_READ, 16'h7FFF, 8'hFF);
    send_access(FUNC_READ, 16'h8000, 8'h00);
    send_access(FUNC_WRITE, 16'h8C05, 8'h5A);
    send_access(FUNC_READ, 16'h8005, 8'h00);
    send_access(FUNC_READ, 16'h8FFF, 8'h00);
    send_access(FUNC_READ, 16'hE810, 8'h00);
    send_access(FUNC_READ, 16'hE82F, 8'h00);
    send_access(FUNC_READ, 16'hE840, 8'h00);
    send_access(FUNC_READ, 16'hE84F, 8'h00);
    send_access(FUNC_READ, CRTC_LO, 8'h00);
    send_access(FUNC_WRITE, CRTC_HI, 8'hAA);
    send_access(FUNC_READ, 16'hE882, 8'h00);
    send_access(FUNC_READ, 16'hFFFF, 8'h00);
    send_access(FUNC_WRITE, 16'h9000, 8'h77);
    send_access(FUNC_LOAD, 16'hF000, 8'h4C);
    send_access(FUNC_READ, 16'hF000, 8'h00);
    send_access(FUNC_WRITE, 16'hF000, 8'h12);
    send_access(FUNC_UNMAP, 16'hF000, 8'h00);
    send_access(FUNC_READ, 16'hF000, 8'h00);
    send_access(FUNC_LOAD, 16'hE810, 8'h33);
    send_access(FUNC_READ, 16'hE810, 8'h00);
    send_access(FUNC_LOAD, 16'h8000, 8'h11);
    send_access(FUNC_READ, 16'h8000, 8'h00);
    send_access(FUNC_WRITE, 16'h8000, 8'h99);
    send_access(FUNC_UNMAP, 16'h8000, 8'h00);
    send_access(FUNC_READ, 16'h8000, 8'h00);
    wait_results();

    write_register(CFG_RAM_SIZE, 17'd0);
    write_register(CFG_SCREEN_MASK, 17'h000);
    run_random(170, 1'b1);
    wait_results();

    write_register(CFG_RAM_SIZE, RAM_SIZE_MAX);
    write_register(CFG_SCREEN_MASK, 17'hFFF);
    run_random(85, 1'b1);
    wait_results();
    run_random(85, 1'b1);
    wait_results();

    write_register(CFG_RAM_SIZE, 17'h1FFFF);
    write_register(CFG_SCREEN_MASK, 17'h7FF);
    write_register(CFG_UNUSED, 17'h1FFFF);
    run_random(170, 1'b1);
    wait_results();

    write_register(CFG_RAM_SIZE, 17'($urandom_range(1, 65535)));
    write_register(CFG_SCREEN_MASK, 17'($urandom_range(0, 4095)));
    run_random(170, 1'b1);
    wait_results();

    write_register(CFG_RAM_SIZE, RAM_SIZE_RESET);
    write_register(CFG_SCREEN_MASK, 17'(SCREEN_MASK_RESET));
    run_random(240, 1'b0);
    wait_results();

    $display("Checked %0d results: %0d reads, %0d writes, %0d ROM loads, %0d ROM unmaps.",
             sb.checked, sb.by_func[FUNC_READ], sb.by_func[FUNC_WRITE],
             sb.by_func[FUNC_LOAD], sb.by_func[FUNC_UNMAP]);
    $display("RAM sizes from 0 to full with saturation, screen masks from 0 to 0xFFF.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ home_computer_memory_map_decoder.f @@
+incdir+hdl
hdl/mmd_pkg.sv
hdl/mmd_ram.sv
hdl/mmd_clear.sv
hdl/mmd_decode.sv
hdl/home_computer_memory_map_decoder.sv
test/home_computer_memory_map_decoder_tb.sv
